/* src/bsprr_pkg.sv */
// Package for the bounded push/pop/rotate stack.
// Holds the operation and status codes and the operation and view structs that the stack uses.
// No dependencies.
package bsprr_pkg;

   localparam int unsigned WordWidth   = 32;
   localparam int unsigned KindWidth   = 2;
   localparam int unsigned StatusWidth = 2;
   localparam int unsigned CountWidth  = 4;

   // Operation codes carried in the kind field.
   localparam logic [KindWidth-1:0] KIND_PUSH   = 2'd0;
   localparam logic [KindWidth-1:0] KIND_POP    = 2'd1;
   localparam logic [KindWidth-1:0] KIND_ROTATE = 2'd2;

   // Status codes returned with each result item.
   localparam logic [StatusWidth-1:0] ST_DONE  = 2'd0;
   localparam logic [StatusWidth-1:0] ST_FULL  = 2'd1;
   localparam logic [StatusWidth-1:0] ST_EMPTY = 2'd2;

   // One operation handed from the control stage to the stack.
   typedef struct packed {
      logic                  fire;
      logic [KindWidth-1:0]  kind;
      logic signed [WordWidth-1:0] value;
   } op_type;

   // View of the stack after the operation that is being applied.
   typedef struct packed {
      logic [StatusWidth-1:0]      status;
      logic signed [WordWidth-1:0] top_value;
   } view_type;

endpackage

/* src/bsprr_req_if.sv */
// Request channel interface of the stack: valid/ready handshake with kind and value.
// Depends on bsprr_pkg.
interface bsprr_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [bsprr_pkg::KindWidth-1:0]       kind;
   logic signed [bsprr_pkg::WordWidth-1:0] value;

   modport source (output valid, output kind, output value, input ready);
   modport sink (input valid, input kind, input value, output ready);
endinterface

/* src/bsprr_rsp_if.sv */
// Response channel interface of the stack: valid/ready handshake with status, top and count.
// Depends on bsprr_pkg.
interface bsprr_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [bsprr_pkg::StatusWidth-1:0]      status;
   logic signed [bsprr_pkg::WordWidth-1:0] top_value;
   logic [bsprr_pkg::CountWidth-1:0]       count;

   modport source (output valid, output status, output top_value, output count, input ready);
   modport sink (input valid, input status, input top_value, input count, output ready);
endinterface

/* src/bounded_stack_push_pop_rotate_core.sv */
// Top level of the bounded push/pop/rotate stack: input register, stack and result register.
// Depends on bsprr_pkg, bsprr_req_if, bsprr_rsp_if and bsprr_stack.
//
//   Channel   Direction   Carries
//   req_ch    in          kind (2 bits), value (32 bits signed)
//   rsp_ch    out         status (2 bits), top_value (32 bits signed), count (4 bits)
//
// Each item passes from acceptance into the input register, then through the stack update
// into the result register. A new item is taken every cycle unless the result channel stalls.
// The stack update is a single parallel shift of the entry registers, so depth does not
// add cycles. Synchronous reset empties the stack and drops any item in flight.
// When the result is not taken, the result register holds and the input register fills,
// after which req_ch.ready falls.
module bounded_stack_push_pop_rotate_core #(
   parameter int unsigned DEPTH = 8
) (
   input  logic            clock,
   input  logic            reset,
   bsprr_req_if.sink       req_ch,
   bsprr_rsp_if.source     rsp_ch
);

   localparam int unsigned FillWidth = $clog2(DEPTH + 1);
   localparam int unsigned CW        = bsprr_pkg::CountWidth;

   logic                                    in_valid_ff;
   logic                                    in_valid_in;
   logic [bsprr_pkg::KindWidth-1:0]         in_kind_ff;
   logic signed [bsprr_pkg::WordWidth-1:0]  in_value_ff;
   logic                                    rsp_valid_ff;
   logic                                    rsp_valid_in;
   logic [bsprr_pkg::StatusWidth-1:0]       rsp_status_ff;
   logic signed [bsprr_pkg::WordWidth-1:0]  rsp_top_ff;
   logic [CW-1:0]                           rsp_count_ff;
   logic                                    advance;
   logic                                    load;
   bsprr_pkg::op_type                       op;
   bsprr_pkg::view_type                     view;
   logic [FillWidth-1:0]                    fill_next;
   logic [FillWidth+CW-1:0]                 fill_wide;

   // Handshake: the result stage moves when empty or taken, the input stage behind it.
   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign load         = !in_valid_ff || advance;
   assign req_ch.ready = load;
   assign in_valid_in  = load ? req_ch.valid : in_valid_ff;
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   assign op.fire  = in_valid_ff && advance;
   assign op.kind  = in_kind_ff;
   assign op.value = in_value_ff;

   bsprr_stack #(
      .DEPTH(DEPTH)
   ) u_stack (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .view      (view),
      .fill_next (fill_next)
   );

   // The count field shows the fill level modulo sixteen.
   assign fill_wide = {{CW{1'b0}}, fill_next};

   // Control registers of both stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers of both stages.
   always_ff @(posedge clock) begin
      if (req_ch.valid && load) begin
         in_kind_ff  <= req_ch.kind;
         in_value_ff <= req_ch.value;
      end
      if (op.fire) begin
         rsp_status_ff <= view.status;
         rsp_top_ff    <= view.top_value;
         rsp_count_ff  <= fill_wide[CW-1:0];
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.status    = rsp_status_ff;
   assign rsp_ch.top_value = rsp_top_ff;
   assign rsp_ch.count     = rsp_count_ff;

endmodule

/* src/bsprr_stack.sv */
// Register stack with push, pop and rotate; entry 0 is always the top of the stack.
// Depends on bsprr_pkg.
module bsprr_stack #(
   parameter int unsigned DEPTH = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bsprr_pkg::op_type             op,
   output bsprr_pkg::view_type           view,
   output logic [$clog2(DEPTH+1)-1:0]    fill_next
);

   localparam int unsigned FillWidth = $clog2(DEPTH + 1);
   localparam int unsigned WW        = bsprr_pkg::WordWidth;

   logic [DEPTH-1:0][WW-1:0] entry_ff;
   logic [DEPTH-1:0][WW-1:0] entry_in;
   logic [FillWidth-1:0]     fill_ff;
   logic [FillWidth-1:0]     fill_in;
   logic [FillWidth-1:0]     last_index;
   logic [DEPTH:0][WW-1:0]   ext_up;
   logic [DEPTH:0][WW-1:0]   ext_down;
   logic                     is_full;
   logic                     is_empty;
   logic [bsprr_pkg::StatusWidth-1:0] status;

   // Entries beyond the fill level are always zero, so whole-array shifts are safe.
   assign is_full    = (fill_ff == FillWidth'(DEPTH));
   assign is_empty   = (fill_ff == '0);
   assign last_index = fill_ff - FillWidth'(1);
   assign ext_up     = {{WW{1'b0}}, entry_ff};
   assign ext_down   = {entry_ff, op.value};

   // Next contents of every entry: a neighbour, the pushed word, or on rotate the old top word.
   always_comb begin
      entry_in = entry_ff;
      fill_in  = fill_ff;
      status   = bsprr_pkg::ST_DONE;
      unique case (op.kind)
         bsprr_pkg::KIND_PUSH: begin
            if (is_full) begin
               status = bsprr_pkg::ST_FULL;
            end else begin
               for (int i = 0; i < DEPTH; i++) begin
                  entry_in[i] = ext_down[i];
               end
               fill_in = fill_ff + FillWidth'(1);
            end
         end
         bsprr_pkg::KIND_POP: begin
            if (is_empty) begin
               status = bsprr_pkg::ST_EMPTY;
            end else begin
               for (int i = 0; i < DEPTH; i++) begin
                  entry_in[i] = ext_up[i+1];
               end
               fill_in = last_index;
            end
         end
         bsprr_pkg::KIND_ROTATE: begin
            if (is_empty) begin
               status = bsprr_pkg::ST_EMPTY;
            end else begin
               for (int i = 0; i < DEPTH; i++) begin
                  if (FillWidth'(i) == last_index) begin
                     entry_in[i] = entry_ff[0];
                  end else begin
                     entry_in[i] = ext_up[i+1];
                  end
               end
            end
         end
         default: begin
            // The unused code leaves the stack as it is.
            status = bsprr_pkg::ST_DONE;
         end
      endcase
   end

   assign view.status    = status;
   assign view.top_value = entry_in[0];
   assign fill_next      = fill_in;

   // The store and the fill level change only when an operation is applied.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         fill_ff  <= '0;
      end else if (op.fire) begin
         entry_ff <= entry_in;
         fill_ff  <= fill_in;
      end
   end

endmodule

/* src/bsprr_checker.sv */
// Port-level checks of the bounded stack's result channel, bound to the top level.
// Depends on bsprr_pkg and bounded_stack_push_pop_rotate_core.
module bsprr_checker #(
   parameter int unsigned DEPTH = 8
) (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic [bsprr_pkg::StatusWidth-1:0]      rsp_status,
   input logic signed [bsprr_pkg::WordWidth-1:0] rsp_top_value,
   input logic [bsprr_pkg::CountWidth-1:0]       rsp_count
);

   // An empty-stack error can only be reported while the stack is empty.
   a_empty_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == bsprr_pkg::ST_EMPTY |-> rsp_count == '0 && rsp_top_value == '0)
      else $error("empty error reported with entries held");

   // A full-stack error can only be reported while every entry is held.
   a_full_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == bsprr_pkg::ST_FULL
         |-> rsp_count == bsprr_pkg::CountWidth'(DEPTH))
      else $error("full error reported with free entries");

   // An empty stack shows a zero top word.
   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_count == '0 && DEPTH < 16 |-> rsp_top_value == '0)
      else $error("non-zero top word on an empty stack");

   // A result item that is not taken stays and keeps its fields.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_top_value)
         && $stable(rsp_count))
      else $error("stalled result item changed");

endmodule

bind bounded_stack_push_pop_rotate_core bsprr_checker #(
   .DEPTH(DEPTH)
) u_bsprr_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_status    (rsp_ch.status),
   .rsp_top_value (rsp_ch.top_value),
   .rsp_count     (rsp_ch.count)
);
